### rtl/view_sector_chunk_sequencer_top_assert.svh
// Assertion macros used by the port-level checker file.
`ifndef VIEW_SECTOR_CHUNK_SEQUENCER_TOP_ASSERT_SVH
`define VIEW_SECTOR_CHUNK_SEQUENCER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define VSCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VSCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/vscs_pkg.sv
// Package with types, constants and the offset table of the chunk sequencer.
package vscs_pkg;
  localparam int unsigned SeqLenDefault  = 32;
  localparam int unsigned MaxCellsDefault = 256;

  localparam logic [1:0] StatusValid = 2'd0;
  localparam logic [1:0] StatusOutside = 2'd1;
  localparam logic [1:0] StatusDone = 2'd2;

  localparam logic [2:0] CfgGridX = 3'd0;
  localparam logic [2:0] CfgGridZ = 3'd1;
  localparam logic [2:0] CfgCellSize = 3'd2;
  localparam logic [2:0] CfgCellsX = 3'd3;
  localparam logic [2:0] CfgCellsZ = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] eye_x;
    logic [31:0] eye_z;
    logic [31:0] dir_x;
    logic [31:0] dir_z;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cell_index;
  } rsp_t;

  typedef struct packed {
    logic               restart;
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic [2:0]         sector;
  } cmd_t;

  // Offsets packed as {dx, dz}, each a 4-bit signed value.
  function automatic logic [7:0] offset_of(input logic [2:0] s, input logic [4:0] k);
    logic signed [3:0] ox;
    logic signed [3:0] oz;
    logic signed [3:0] a;
    logic signed [3:0] b;
    logic [7:0] base;
    base = 8'h00;
    case (k)
      5'd0: base = {4'sd0, 4'sd0};
      5'd1: base = {4'sd0, 4'sd1};
      5'd2: base = {-4'sd1, 4'sd1};
      5'd3: base = {-4'sd1, 4'sd0};
      5'd4: base = {4'sd1, 4'sd0};
      5'd5: base = {4'sd0, 4'sd2};
      5'd6: base = {-4'sd1, 4'sd2};
      5'd7: base = {4'sd1, 4'sd1};
      5'd8: base = {-4'sd2, 4'sd1};
      5'd9: base = {-4'sd2, 4'sd0};
      5'd10: base = {4'sd1, 4'sd2};
      5'd11: base = {-4'sd2, 4'sd2};
      5'd12: base = {4'sd2, 4'sd3};
      5'd13: base = {-4'sd3, 4'sd1};
      5'd14: base = {4'sd0, 4'sd3};
      5'd15: base = {4'sd1, 4'sd3};
      5'd16: base = {-4'sd1, 4'sd3};
      5'd17: base = {4'sd2, 4'sd3};
      5'd18: base = {-4'sd2, 4'sd3};
      5'd19: base = {-4'sd3, 4'sd2};
      5'd20: base = {4'sd0, 4'sd4};
      5'd21: base = {-4'sd1, 4'sd4};
      5'd22: base = {4'sd1, 4'sd4};
      5'd23: base = {-4'sd2, 4'sd4};
      5'd24: base = {4'sd2, 4'sd4};
      5'd25: base = {-4'sd3, 4'sd3};
      5'd26: base = {-4'sd4, 4'sd2};
      5'd27: base = {4'sd3, 4'sd4};
      5'd28: base = {-4'sd3, 4'sd4};
      5'd29: base = {-4'sd4, 4'sd3};
      5'd30: base = {4'sd0, 4'sd5};
      default: base = {-4'sd1, 4'sd5};
    endcase
    // Sector 0 is the base list; the others are rotations and mirrors of it.
    a = base[7:4];
    b = base[3:0];
    ox = a;
    oz = b;
    case (s)
      3'd0: begin ox = a; oz = b; end
      3'd1: begin ox = -b; oz = -a; end
      3'd2: begin ox = -b; oz = a; end
      3'd3: begin ox = a; oz = -b; end
      3'd4: begin ox = -a; oz = -b; end
      3'd5: begin ox = b; oz = a; end
      3'd6: begin ox = b; oz = -a; end
      default: begin ox = -a; oz = b; end
    endcase
    return {ox, oz};
  endfunction
endpackage

### rtl/vscs_if.sv
// Valid-ready channel interface carrying one payload item.
interface vscs_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/vscs_front.sv
// Front part: accepts requests, finds the view sector and the eye offsets.
module vscs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vscs_pkg::req_t     in_data_i,
  input  logic [31:0]        org_x_i,
  input  logic [31:0]        org_z_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output vscs_pkg::cmd_t     cmd_o
);
  import vscs_pkg::*;

  logic        full_q, full_d;
  cmd_t        cmd_q, cmd_d;
  logic signed [32:0] y, x, ny, nx;
  logic [2:0]  sec;

  always_comb begin
    y = {in_data_i.dir_x[31], in_data_i.dir_x};
    x = -{in_data_i.dir_z[31], in_data_i.dir_z};
    ny = -y;
    nx = -x;
    if (y == 0) sec = (x < 0) ? 3'd0 : 3'd4;
    else if (y > 0) begin
      if (x > 0) sec = (y < x) ? 3'd4 : 3'd5;
      else if (x == 0) sec = 3'd6;
      else sec = (y > nx) ? 3'd6 : 3'd7;
    end else begin
      if (x > 0) sec = (ny <= x) ? 3'd3 : 3'd2;
      else if (x == 0) sec = 3'd2;
      else sec = (ny >= nx) ? 3'd1 : 3'd0;
    end
  end

  assign in_ready_o = !full_q;
  assign cmd_valid_o = full_q;
  assign cmd_o = cmd_q;

  always_comb begin
    full_d = full_q;
    cmd_d = cmd_q;
    if (full_q && cmd_ready_i) full_d = 1'b0;
    if (in_valid_i && !full_q) begin
      full_d = 1'b1;
      cmd_d.restart = in_data_i.kind;
      cmd_d.dx = $signed({in_data_i.eye_x[31], in_data_i.eye_x}) -
                 $signed({org_x_i[31], org_x_i});
      cmd_d.dz = $signed({in_data_i.eye_z[31], in_data_i.eye_z}) -
                 $signed({org_z_i[31], org_z_i});
      cmd_d.sector = sec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else full_q <= full_d;
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end
endmodule

### rtl/vscs_back.sv
// Back part: divides by the cell size, walks the offset list, forms results.
module vscs_back #(
  parameter int unsigned SeqLen = vscs_pkg::SeqLenDefault,
  parameter int unsigned MaxCells = vscs_pkg::MaxCellsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  vscs_pkg::cmd_t   cmd_i,
  input  logic [30:0]      cell_size_i,
  input  logic [8:0]       cells_x_i,
  input  logic [8:0]       cells_z_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vscs_pkg::rsp_t   out_o
);
  import vscs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;
  localparam logic [5:0] SeqEnd = 6'(SeqLen);
  localparam logic [8:0] MaxC = 9'(MaxCells);

  logic [1:0]  st_q, st_d;
  logic [5:0]  step_q, step_d;
  logic signed [15:0] bx_q, bx_d, bz_q, bz_d;
  logic [2:0]  sec_q, sec_d;
  logic        ov_q, ov_d;
  rsp_t        out_q, out_d;
  // Divider: restoring, one quotient bit a cycle, both axes together.
  logic [31:0] nx_q, nx_d, nz_q, nz_d;
  logic [31:0] qx_q, qx_d, qz_q, qz_d;
  logic [31:0] rx_q, rx_d, rz_q, rz_d;
  logic        sx_q, sx_d, sz_q, sz_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [30:0] dv;
  logic [32:0] trx, trz;
  logic [7:0]  off;
  logic signed [17:0] ex, ez;
  logic [8:0]  cx, cz;
  logic [16:0] lin;

  function automatic logic signed [15:0] floor_sat(input logic neg, input logic [31:0] q,
                                                   input logic [31:0] r);
    logic [32:0] mag;
    logic signed [33:0] v;
    mag = {1'b0, q} + ((neg && r != 32'd0) ? 33'd1 : 33'd0);
    v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (v > 34'sd32767) return 16'sh7fff;
    if (v < -34'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  assign dv = (cell_size_i == 31'd0) ? 31'd1 : cell_size_i;
  assign cx = (cells_x_i > MaxC) ? MaxC : cells_x_i;
  assign cz = (cells_z_i > MaxC) ? MaxC : cells_z_i;
  assign trx = {rx_q, nx_q[31]} - {2'b00, dv};
  assign trz = {rz_q, nz_q[31]} - {2'b00, dv};
  assign off = offset_of(sec_q, step_q[4:0]);
  assign ex = 18'(bx_q) + 18'($signed(off[7:4]));
  assign ez = 18'(bz_q) + 18'($signed(off[3:0]));
  assign lin = 17'(ex[15:0]) + 17'(cx) * 17'(ez[7:0]);

  assign cmd_ready_o = (st_q == StIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_o = out_q;

  always_comb begin
    st_d = st_q; step_d = step_q; bx_d = bx_q; bz_d = bz_q; sec_d = sec_q;
    ov_d = ov_q; out_d = out_q;
    nx_d = nx_q; nz_d = nz_q; qx_d = qx_q; qz_d = qz_q; rx_d = rx_q; rz_d = rz_q;
    sx_d = sx_q; sz_d = sz_q; cnt_d = cnt_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (cmd_valid_i && !ov_q) begin
          if (cmd_i.restart) begin
            sx_d = cmd_i.dx[32];
            sz_d = cmd_i.dz[32];
            nx_d = 32'(cmd_i.dx[32] ? -cmd_i.dx : cmd_i.dx);
            nz_d = 32'(cmd_i.dz[32] ? -cmd_i.dz : cmd_i.dz);
            qx_d = '0; qz_d = '0; rx_d = '0; rz_d = '0;
            cnt_d = 6'd32;
            sec_d = cmd_i.sector;
            step_d = '0;
            st_d = StDiv;
          end else begin
            st_d = StEmit;
          end
        end
      end
      StDiv: begin
        nx_d = {nx_q[30:0], 1'b0};
        nz_d = {nz_q[30:0], 1'b0};
        if (!trx[32]) begin rx_d = trx[31:0]; qx_d = {qx_q[30:0], 1'b1}; end
        else begin rx_d = {rx_q[30:0], nx_q[31]}; qx_d = {qx_q[30:0], 1'b0}; end
        if (!trz[32]) begin rz_d = trz[31:0]; qz_d = {qz_q[30:0], 1'b1}; end
        else begin rz_d = {rz_q[30:0], nz_q[31]}; qz_d = {qz_q[30:0], 1'b0}; end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) st_d = StEmit;
      end
      StEmit: begin
        st_d = StIdle;
        ov_d = 1'b1;
        if (step_q >= SeqEnd) begin
          out_d = {StatusDone, 16'd0};
        end else begin
          step_d = step_q + 6'd1;
          if (ex < 0 || ez < 0 || ex >= 18'sd0 + 18'(cx) || ez >= 18'sd0 + 18'(cz))
            out_d = {StatusOutside, 16'd0};
          else out_d = {StatusValid, lin[15:0]};
        end
      end
      default: st_d = StIdle;
    endcase
    if (st_q == StDiv && cnt_q == 6'd1) begin
      bx_d = floor_sat(sx_q, {qx_q[30:0], !trx[32]},
                       !trx[32] ? trx[31:0] : {rx_q[30:0], nx_q[31]});
      bz_d = floor_sat(sz_q, {qz_q[30:0], !trz[32]},
                       !trz[32] ? trz[31:0] : {rz_q[30:0], nz_q[31]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; step_q <= '0; bx_q <= '0; bz_q <= '0; sec_q <= '0;
      ov_q <= 1'b0; cnt_q <= '0;
    end else begin
      st_q <= st_d; step_q <= step_d; bx_q <= bx_d; bz_q <= bz_d; sec_q <= sec_d;
      ov_q <= ov_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    nx_q <= nx_d; nz_q <= nz_d; qx_q <= qx_d; qz_q <= qz_d;
    rx_q <= rx_d; rz_q <= rz_d; sx_q <= sx_d; sz_q <= sz_d;
  end
endmodule

### rtl/view_sector_chunk_sequencer_top.sv
// Top level of the view-sector chunk sequencer.
// Usage: requests arrive on in_ch as items; each item gives exactly one
// result item on out_ch. A restart item carries eye position and view
// direction; a next item only steps through the offset list.
// Registers are to be written on cfg_ch (index 0 to 4) only while the
// block is idle; the block itself does not enforce this. A next item
// goes from idle to the emit state; a restart first runs the bit-serial
// divider that finds both cell coordinates, one quotient bit per cycle.
// The back part holds one item at a time and takes a new one only once
// the last result has left the output register; a queue stage in front
// holds one further item meanwhile.
// Reset clears the step counter, the stored cell and sector, and loads the
// register reset values. When the receiver stalls, the result waits in the
// output register and the back part holds; the front takes one more item.
module view_sector_chunk_sequencer_top #(
  parameter int unsigned SeqLen = vscs_pkg::SeqLenDefault,
  parameter int unsigned MaxCells = vscs_pkg::MaxCellsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  vscs_if.sink   in_ch,
  vscs_if.source out_ch,
  vscs_if.sink   cfg_ch
);
  import vscs_pkg::*;

  logic [31:0] orgx_q, orgz_q;
  logic [30:0] size_q;
  logic [8:0]  cx_q, cz_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [34:0] cfg_w;

  assign cfg_ch.ready = 1'b1;
  assign cfg_w = cfg_ch.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orgx_q <= '0; orgz_q <= '0; size_q <= 31'd65536; cx_q <= 9'd1; cz_q <= 9'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_w[34:32])
        CfgGridX: orgx_q <= cfg_w[31:0];
        CfgGridZ: orgz_q <= cfg_w[31:0];
        CfgCellSize: size_q <= cfg_w[30:0];
        CfgCellsX: cx_q <= cfg_w[8:0];
        CfgCellsZ: cz_q <= cfg_w[8:0];
        default: ;
      endcase
    end
  end

  vscs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_data_i(in_ch.data),
    .org_x_i(orgx_q), .org_z_i(orgz_q),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  vscs_back #(.SeqLen(SeqLen), .MaxCells(MaxCells)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .cell_size_i(size_q), .cells_x_i(cx_q), .cells_z_i(cz_q),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_o(out_ch.data)
  );
endmodule

### rtl/vscs_checker.sv
// Port-level checker for the chunk sequencer, bound to the top level.
`include "view_sector_chunk_sequencer_top_assert.svh"
module vscs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] status_i,
  input logic [15:0] cell_index_i
);
  import vscs_pkg::*;
  `VSCS_ASSERT_IMP(a_zero_idx, clk_i, rst_ni, out_valid_i && status_i != StatusValid, cell_index_i == 16'd0)
  `VSCS_ASSERT_IMP(a_status_ok, clk_i, rst_ni, out_valid_i, status_i != 2'd3)
  `VSCS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i))
  `VSCS_ASSERT_NEXT(a_take_one, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
endmodule

bind view_sector_chunk_sequencer_top vscs_checker u_vscs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .status_i(out_ch.data.status), .cell_index_i(out_ch.data.cell_index)
);

### bench/vscs_bench_pkg.sv
// Shared testbench types: the register write item of the configuration channel.
`timescale 1ns / 100ps
package vscs_bench_pkg;
  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] wdata;
  } cfg_t;
endpackage

### bench/chunk_choice_checker.sv
// Checker that predicts every chunk choice and compares it with the block's results.
`timescale 1ns / 100ps
module chunk_choice_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  vscs_if             in_ch,
  vscs_if             out_ch,
  vscs_if             cfg_ch,
  output int unsigned fail_count,
  output int unsigned choices_pending
);
  import vscs_pkg::*;

  localparam int ListLen = 32;
  localparam int CountCap = 256;

  // Sector 0 offsets; the other sectors are rotations and mirrors of this list.
  localparam int BaseX [ListLen] = '{0, 0, -1, -1, 1, 0, -1, 1, -2, -2, 1, -2, 2, -3, 0, 1,
                                     -1, 2, -2, -3, 0, -1, 1, -2, 2, -3, -4, 3, -3, -4, 0, -1};
  localparam int BaseZ [ListLen] = '{0, 1, 1, 0, 0, 2, 2, 1, 1, 0, 2, 2, 3, 1, 3, 3,
                                     3, 3, 3, 2, 4, 4, 4, 4, 4, 3, 2, 4, 4, 3, 5, 5};

  logic [31:0] origin_x, origin_z;
  logic [30:0] size_reg;
  logic [8:0]  across_x, across_z;
  int          steps_taken;
  int          anchor_x, anchor_z;
  logic [2:0]  sector_reg;
  rsp_t        choice_q[$];

  function automatic int floor_cell(longint eye, longint origin, longint size);
    longint d, q;
    d = eye - origin;
    if (size == 0) size = 1;
    q = d / size;
    if ((d % size) != 0 && d < 0) q = q - 1;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic logic [2:0] sector_from(longint y, longint x);
    if (y == 0) return (x < 0) ? 3'd0 : 3'd4;
    if (y > 0) begin
      if (x > 0) return (y < x) ? 3'd4 : 3'd5;
      if (x == 0) return 3'd6;
      return (y > -x) ? 3'd6 : 3'd7;
    end
    if (x > 0) return (-y <= x) ? 3'd3 : 3'd2;
    if (x == 0) return 3'd2;
    return (-y >= -x) ? 3'd1 : 3'd0;
  endfunction

  function automatic rsp_t next_choice(req_t r);
    int   a, b, ox, oz, nx, nz, cx, cz;
    rsp_t res;
    cx = (across_x > CountCap) ? CountCap : int'(across_x);
    cz = (across_z > CountCap) ? CountCap : int'(across_z);
    if (r.kind) begin
      anchor_x = floor_cell(longint'($signed(r.eye_x)), longint'($signed(origin_x)),
                            longint'(size_reg));
      anchor_z = floor_cell(longint'($signed(r.eye_z)), longint'($signed(origin_z)),
                            longint'(size_reg));
      sector_reg = sector_from(longint'($signed(r.dir_x)), -longint'($signed(r.dir_z)));
      steps_taken = 0;
    end
    res = '0;
    if (steps_taken >= ListLen) begin
      res.status = StatusDone;
      return res;
    end
    a = BaseX[steps_taken];
    b = BaseZ[steps_taken];
    case (sector_reg)
      3'd0: begin ox = a; oz = b; end
      3'd1: begin ox = -b; oz = -a; end
      3'd2: begin ox = -b; oz = a; end
      3'd3: begin ox = a; oz = -b; end
      3'd4: begin ox = -a; oz = -b; end
      3'd5: begin ox = b; oz = a; end
      3'd6: begin ox = b; oz = -a; end
      default: begin ox = -a; oz = b; end
    endcase
    steps_taken++;
    nx = anchor_x + ox;
    nz = anchor_z + oz;
    if (nx < 0 || nz < 0 || nx >= cx || nz >= cz) begin
      res.status = StatusOutside;
    end else begin
      res.status = StatusValid;
      res.cell_index = 16'(nx + cx * nz);
    end
    return res;
  endfunction

  task automatic report(string what, int unsigned want, int unsigned got);
    $display("%0t mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  assign choices_pending = choice_q.size();

  initial begin
    fail_count = 0;
    origin_x = '0;
    origin_z = '0;
    size_reg = 31'd65536;
    across_x = 9'd1;
    across_z = 9'd1;
    steps_taken = 0;
    anchor_x = 0;
    anchor_z = 0;
    sector_reg = 3'd0;
  end

  // Handshakes are sampled half a period before the edge that takes them.
  always @(negedge clk_i) begin
    rsp_t want, got;
    vscs_bench_pkg::cfg_t w;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        w = cfg_ch.data;
        case (w.index)
          CfgGridX: origin_x = w.wdata;
          CfgGridZ: origin_z = w.wdata;
          CfgCellSize: size_reg = w.wdata[30:0];
          CfgCellsX: across_x = w.wdata[8:0];
          CfgCellsZ: across_z = w.wdata[8:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) choice_q.push_back(next_choice(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (choice_q.size() == 0) begin
          report("unexpected result item", 0, 1);
        end else begin
          want = choice_q.pop_front();
          if (got.status !== want.status) report("status", want.status, got.status);
          if (got.cell_index !== want.cell_index) begin
            report("cell_index", want.cell_index, got.cell_index);
          end
        end
      end
    end
  end
endmodule

### bench/testbench.sv
// Top of the chunk sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import vscs_pkg::*;
  import vscs_bench_pkg::*;

  localparam int StallLimit = 3000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count, choices_pending;
  int unsigned quiet_cycles;
  bit          no_stall_mode;
  logic [31:0] org_x, org_z;
  logic [30:0] cur_size;
  int          cur_cx, cur_cz;

  vscs_if #(.T(req_t)) in_ch ();
  vscs_if #(.T(rsp_t)) out_ch ();
  vscs_if #(.T(cfg_t)) cfg_ch ();

  view_sector_chunk_sequencer_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  chunk_choice_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .fail_count     (fail_count),
    .choices_pending(choices_pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic wait_taken(input bit is_cfg);
    bit taken;
    do begin
      @(negedge clk_i);
      taken = is_cfg ? cfg_ch.ready : in_ch.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, wdata: val};
    wait_taken(1'b1);
    case (idx)
      CfgGridX: org_x = val;
      CfgGridZ: org_z = val;
      CfgCellSize: cur_size = val[30:0];
      CfgCellsX: cur_cx = int'(val[8:0]);
      CfgCellsZ: cur_cz = int'(val[8:0]);
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] ox, input logic [31:0] oz,
                          input logic [31:0] sz, input logic [31:0] nx, input logic [31:0] nz);
    in_ch.valid <= 1'b0;
    while (choices_pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    write_reg(CfgGridX, ox);
    write_reg(CfgGridZ, oz);
    write_reg(CfgCellSize, sz);
    write_reg(CfgCellsX, nx);
    write_reg(CfgCellsZ, nz);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send(input logic kind, input logic [31:0] ex, input logic [31:0] ez,
                      input logic [31:0] dx, input logic [31:0] dz);
    int gap;
    gap = no_stall_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{kind: kind, eye_x: ex, eye_z: ez, dir_x: dx, dir_z: dz};
    wait_taken(1'b0);
  endtask

  function automatic logic [31:0] eye_near(input logic [31:0] org, input int span);
    longint c, s;
    s = (cur_size == 0) ? 1 : longint'(cur_size);
    c = longint'($urandom_range(0, span + 5)) - 3;
    return 32'(longint'($signed(org)) + c * s + longint'($urandom) % s);
  endfunction

  function automatic logic [31:0] dir_value();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic random_walks(input int items);
    int n, nexts;
    logic [31:0] dx, dz;
    n = 0;
    while (n < items) begin
      if ($urandom_range(0, 9) == 0) begin
        send(1'b0, $urandom, $urandom, $urandom, $urandom);
        n++;
      end else begin
        dx = dir_value();
        dz = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? dx : -dx)
                                         : dir_value();
        send(1'b1, eye_near(org_x, cur_cx), eye_near(org_z, cur_cz), dx, dz);
        nexts = ($urandom_range(0, 3) == 0) ? $urandom_range(31, 36) : $urandom_range(0, 12);
        repeat (nexts) send(1'b0, $urandom, $urandom, $urandom, $urandom);
        n += nexts + 1;
      end
    end
  endtask

  // Result side: a random stall before each item, with stretches of none.
  initial begin
    int gap;
    bit taken;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = no_stall_mode ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        taken = out_ch.valid;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("[view_sector_chunk_sequencer_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sweep;
    no_stall_mode = 1'b0;
    org_x = '0;
    org_z = '0;
    cur_size = 31'd65536;
    cur_cx = 1;
    cur_cz = 1;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk from reset without a restart, sector boundaries, zero direction, extreme values.
    repeat (3) send(1'b0, '0, '0, '0, '0);
    set_grid(32'h0, 32'h0, 32'h10000, 32'd8, 32'd8);
    send(1'b1, 32'h40000, 32'h40000, 32'h0, 32'h0);
    send(1'b1, 32'h40000, 32'h40000, 32'h0, 32'h10000);
    send(1'b1, 32'h40000, 32'h40000, 32'h10000, 32'hffff0000);
    send(1'b1, 32'h40000, 32'h40000, 32'h10000, 32'h0);
    send(1'b1, 32'h40000, 32'h40000, 32'h10000, 32'h10000);
    send(1'b1, 32'h40000, 32'h40000, 32'h0, 32'hffff0000);
    send(1'b1, 32'h40000, 32'h40000, 32'hffff0000, 32'h10000);
    send(1'b1, 32'h40000, 32'h40000, 32'hffff0000, 32'h0);
    send(1'b1, 32'h40000, 32'h40000, 32'hffff0000, 32'hffff0000);
    send(1'b1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send(1'b1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send(1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    set_grid(32'h80000000, 32'h7fffffff, 32'h0, 32'd511, 32'd0);
    send(1'b1, 32'h7fffffff, 32'h80000000, 32'h1, 32'h1);
    send(1'b0, '0, '0, '0, '0);
    set_grid(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd256, 32'd256);
    send(1'b1, 32'h80000000, 32'h7fffffff, 32'h5, 32'h0);
    send(1'b0, '0, '0, '0, '0);

    for (sweep = 0; sweep < 6; sweep++) begin
      case (sweep)
        0: set_grid(32'h0, 32'h0, 32'h10000, 32'd16, 32'd16);
        1: set_grid($urandom, $urandom, 32'd1, 32'd256, 32'd256);
        2: set_grid($urandom, $urandom, 32'($urandom_range(1, 32'h7fffffff)),
                    32'd1, 32'd1);
        3: set_grid(32'hfff00000, 32'h00100000, 32'h8000,
                    $urandom_range(1, 40), $urandom_range(1, 40));
        4: set_grid($urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_grid(32'hffffffff, 32'h0, 32'h7fffffff, 32'd300, 32'd2);
      endcase
      no_stall_mode = (sweep == 2);
      random_walks(70);
    end
    no_stall_mode = 1'b0;
    in_ch.valid <= 1'b0;

    while (choices_pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[view_sector_chunk_sequencer_top] OK");
    end else begin
      $display("[view_sector_chunk_sequencer_top] ERROR");
    end
    $finish;
  end
endmodule
